// File: design/tws_pkg.sv
`default_nettype none

package tws_pkg;

  // Wheel geometry (SLOTS must stay a power of two: slot math is a mask)
  localparam int SLOTS      = 64;
  localparam int TIMERS     = 32;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int TID_W      = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  // Field widths
  localparam int KIND_W     = 2;
  localparam int ID_W       = 5;
  localparam int DELAY_W    = 20;
  localparam int IVAL_W     = 10;
  localparam int ROUNDS_W   = 14;
  localparam int ROUNDS_MAX = (1 << ROUNDS_W) - 1;
  localparam int DCNT_W     = $clog2(DELAY_W + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 2'd0,
    KIND_REARM = 2'd1,
    KIND_DEL   = 2'd2,
    KIND_TICK  = 2'd3
  } tws_kind_t;

  typedef struct packed {
    tws_kind_t          kind;
    logic [ID_W-1:0]    timer_id;
    logic [DELAY_W-1:0] delay;
  } tws_in_t;

  typedef struct packed {
    logic [ID_W-1:0] expired_id;
    logic            last_expired;
  } tws_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_WRITE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_FLUSH
  } tws_state_t;

  // Controller to datapath
  typedef struct packed {
    logic div_init;
    logic div_step;
    logic write;
    logic del;
    logic scan_init;
    logic scan_read;
    logic scan_eval;
    logic flush;
    logic advance;
  } tws_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_sched;
    logic req_del;
    logic req_tick;
    logic div_last;
    logic scan_last;
    logic hit_expire;
    logic pend_valid;
    logic out_free;
  } tws_sts_t;

endpackage

`default_nettype wire

// File: design/tws_ctrl.sv
`default_nettype none

module tws_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tws_pkg::tws_sts_t sts,
  output tws_pkg::tws_cmd_t  cmd
);
  import tws_pkg::*;

  tws_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (sts.req_tick) begin
            cmd.scan_init = 1'b1;
            state_nxt     = ST_SCAN_RD;
          end else if (sts.req_sched) begin
            cmd.div_init = 1'b1;
            state_nxt    = ST_DIV;
          end else if (sts.req_del) begin
            cmd.del = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCAN_RD: begin
        cmd.scan_read = 1'b1;
        state_nxt     = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        // hold while a second expiry would need the busy output register
        if (!(sts.hit_expire && sts.pend_valid && !sts.out_free)) begin
          cmd.scan_eval = 1'b1;
          state_nxt     = sts.scan_last ? ST_FLUSH : ST_SCAN_RD;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          cmd.advance = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.flush   = 1'b1;
          cmd.advance = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_ready_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(cmd.scan_eval || cmd.div_step || cmd.write || cmd.flush))
    else $error("request taken while busy");

  a_div_then_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && sts.div_last) |=> cmd.write)
    else $error("divide finished without entry write");

  a_flush_advances: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> cmd.advance)
    else $error("final expiry pushed without slot advance");

endmodule

`default_nettype wire

// File: design/tws_dp.sv
`default_nettype none

module tws_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tws_pkg::tws_in_t  in_req,
  input  wire logic              cfg_we,
  input  wire logic [tws_pkg::IVAL_W-1:0] cfg_wdata,
  input  wire tws_pkg::tws_cmd_t cmd,
  output tws_pkg::tws_sts_t      sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tws_pkg::tws_out_t      out_res
);
  import tws_pkg::*;

  logic [IVAL_W-1:0]   ival_r;
  logic [TIMERS-1:0]   valid_r;
  logic [SLOT_W-1:0]   cur_r;

  logic [ROUNDS_W-1:0] rounds_mem [TIMERS];
  logic [SLOT_W-1:0]   slot_mem   [TIMERS];
  logic [ROUNDS_W-1:0] rd_rounds_r;
  logic [SLOT_W-1:0]   rd_slot_r;

  logic [TID_W-1:0]    id_r;
  logic                dzero_r;
  logic [DELAY_W-1:0]  quo_r;
  logic [IVAL_W-1:0]   rem_r;
  logic [DCNT_W-1:0]   dcnt_r;

  logic [TID_W-1:0]    scan_idx_r;
  logic                pend_valid_r;
  logic [ID_W-1:0]     pend_id_r;
  logic                out_valid_r;
  tws_out_t            out_res_r;

  logic [IVAL_W-1:0]   ival;
  logic [IVAL_W:0]     trial;
  logic                ge;
  logic [DELAY_W-1:0]  ticks;
  logic [DELAY_W-1:0]  rnd_full;
  logic [ROUNDS_W-1:0] rounds_new;
  logic [SLOT_W-1:0]   slot_new;
  logic [TID_W-1:0]    req_idx;
  logic                id_ok;
  logic                hit;
  logic                expire;
  logic                dec;
  logic                push;
  tws_out_t            push_res;

  assign ival     = (ival_r == '0) ? IVAL_W'(1) : ival_r;
  assign trial    = {rem_r, quo_r[DELAY_W-1]};
  assign ge       = trial >= {1'b0, ival};

  assign ticks      = dzero_r ? DELAY_W'(1) : quo_r;
  assign rnd_full   = ticks >> SLOT_W;
  assign rounds_new = (rnd_full > DELAY_W'(ROUNDS_MAX)) ? ROUNDS_W'(ROUNDS_MAX)
                                                         : rnd_full[ROUNDS_W-1:0];
  assign slot_new   = cur_r + ticks[SLOT_W-1:0];

  assign req_idx = in_req.timer_id[TID_W-1:0];
  assign id_ok   = 32'(in_req.timer_id) < TIMERS;

  assign hit    = valid_r[scan_idx_r] && (rd_slot_r == cur_r);
  assign expire = hit && (rd_rounds_r == '0);
  assign dec    = cmd.scan_eval && hit && (rd_rounds_r != '0);

  assign sts.req_tick   = in_req.kind == KIND_TICK;
  assign sts.req_sched  = id_ok && ((in_req.kind == KIND_ADD) ||
                          ((in_req.kind == KIND_REARM) && valid_r[req_idx]));
  assign sts.req_del    = id_ok && (in_req.kind == KIND_DEL);
  assign sts.div_last   = dcnt_r == DCNT_W'(1);
  assign sts.scan_last  = scan_idx_r == TID_W'(TIMERS - 1);
  assign sts.hit_expire = expire;
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  // a new expiry pushes the held one out as not-last; flush pushes it as last
  assign push = cmd.flush || (cmd.scan_eval && expire && pend_valid_r);
  assign push_res.expired_id   = pend_id_r;
  assign push_res.last_expired = cmd.flush;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ival_r <= IVAL_W'(1);
    end else if (cfg_we) begin
      ival_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      cur_r        <= '0;
      dcnt_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.write) begin
        valid_r[id_r] <= 1'b1;
      end
      if (cmd.del) begin
        valid_r[req_idx] <= 1'b0;
      end
      if (cmd.scan_eval && expire) begin
        valid_r[scan_idx_r] <= 1'b0;
      end
      if (cmd.advance) begin
        cur_r <= cur_r + SLOT_W'(1);
      end
      if (cmd.div_init) begin
        dcnt_r <= DCNT_W'(DELAY_W);
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r - DCNT_W'(1);
      end
      if (cmd.scan_init || cmd.flush) begin
        pend_valid_r <= 1'b0;
      end else if (cmd.scan_eval && expire) begin
        pend_valid_r <= 1'b1;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      id_r    <= req_idx;
      dzero_r <= in_req.delay == '0;
      quo_r   <= in_req.delay;
      rem_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? IVAL_W'(trial - {1'b0, ival}) : trial[IVAL_W-1:0];
      quo_r <= {quo_r[DELAY_W-2:0], ge};
    end
    if (cmd.scan_init) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_eval) begin
      scan_idx_r <= scan_idx_r + TID_W'(1);
    end
    if (cmd.scan_eval && expire) begin
      pend_id_r <= ID_W'(scan_idx_r);
    end
    if (push) begin
      out_res_r <= push_res;
    end
  end

  // entry memories: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      rounds_mem[id_r] <= rounds_new;
      slot_mem[id_r]   <= slot_new;
    end else if (dec) begin
      rounds_mem[scan_idx_r] <= rd_rounds_r - ROUNDS_W'(1);
    end
    if (cmd.scan_read) begin
      rd_rounds_r <= rounds_mem[scan_idx_r];
      rd_slot_r   <= slot_mem[scan_idx_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_write_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> dcnt_r == '0)
    else $error("entry written before divide finished");

  a_expire_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_eval && expire) |=> !valid_r[$past(scan_idx_r)])
    else $error("expired entry still valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!out_valid_r || out_ready))
    else $error("output overwritten before taken");

  a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |=> cur_r == $past(cur_r) + SLOT_W'(1))
    else $error("current slot did not advance by one");

endmodule

`default_nettype wire

// File: design/timing_wheel_scheduler.sv
// Sequence: add/re-arm runs a 20-step divide, one entry write, then returns to idle;
//   delete completes in idle; tick accepts, then per entry does one read and one
//   evaluate step over the entry memory, then a flush, and can be held by output stalls.
// Requests are taken one at a time, only in idle, after the previous one completes.
// Reset (rst_n low, synchronous): all entries invalid, current slot zero,
//   tick_interval back to 1, output empty. No clearing pass is needed.
`default_nettype none

module timing_wheel_scheduler (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire tws_pkg::tws_in_t           in_req,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output tws_pkg::tws_out_t               out_res,
  input  wire logic                       cfg_we,
  input  wire logic [tws_pkg::IVAL_W-1:0] cfg_wdata
);
  import tws_pkg::*;

  // Controller and datapath talk only through these two bundles.
  tws_cmd_t cmd;
  tws_sts_t sts;

  // Sequencer: accept a request in idle (a delete completes there), run the divider for
  // add/re-arm, sweep every entry for a tick, then flush any held expiry with last set.
  tws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: interval register, valid flops, entry memories, restoring
  // divider, one-deep expiry hold register and the output register.
  // The hold register lets each expiry learn whether it is the last one.
  tws_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire

// File: bench/timing_wheel_scheduler_tb.sv
`default_nettype none

module timing_wheel_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tws_pkg::*;

  // Cycles without any handshake before the run is declared hung. The slowest
  // legal stretch is a full-wheel tick plus 32 expiries each behind the longest
  // random stall, or the long receiver hold-off below; take it several times.
  localparam int WATCHDOG_LIMIT = 4000;
  // Quiet time once no expiry is pending: covers a trailing tick scan or a
  // schedule that produces nothing visible.
  localparam int SETTLE_CYCLES  = 100;
  localparam int LONG_HOLD      = 400;
  localparam int REPORT_LIMIT   = 10;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  tws_in_t           in_req    = '0;
  logic              out_valid;
  logic              out_ready = 1'b1;
  tws_out_t          out_res;
  logic              cfg_we    = 1'b0;
  logic [IVAL_W-1:0] cfg_wdata = '0;

  timing_wheel_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow wheel: our own copy of the timer table, the wheel position and the
  // interval register, advanced on every accepted request.
  // ---------------------------------------------------------------------------
  bit [IVAL_W-1:0]   wheel_interval = 1;
  bit                wheel_armed  [TIMERS];
  bit [ROUNDS_W-1:0] wheel_rounds [TIMERS];
  bit [SLOT_W-1:0]   wheel_slot   [TIMERS];
  bit [SLOT_W-1:0]   wheel_now    = '0;

  // Expiries the wheel owes us, oldest first.
  tws_out_t expiry_q[$];

  int requests_sent  = 0;
  int expiries_seen  = 0;
  int mismatches     = 0;
  int settings_used  = 0;

  // Random idling on both sides; cleared for the closing stretch of the run.
  bit gaps_on           = 1'b1;
  // Set by a test to make the receiver hold off for that many cycles.
  int sink_hold_cycles  = 0;

  // Convert a delay to ticks and place the timer on the wheel.
  function automatic void schedule_timer(input bit [ID_W-1:0] id,
                                         input bit [DELAY_W-1:0] delay);
    int unsigned divisor;
    int unsigned ticks;
    int unsigned rounds;
    // A zero interval acts as one time unit per tick.
    divisor = (wheel_interval == 0) ? 1 : wheel_interval;
    // Zero delay still means one tick; a delay shorter than the interval gives
    // zero ticks and lands in the current slot, due on the very next tick.
    ticks  = (delay == 0) ? 1 : delay / divisor;
    rounds = ticks / SLOTS;
    if (rounds > ROUNDS_MAX) rounds = ROUNDS_MAX;
    wheel_rounds[id] = ROUNDS_W'(rounds);
    wheel_slot[id]   = SLOT_W'((wheel_now + ticks) % SLOTS);
    wheel_armed[id]  = 1'b1;
  endfunction

  // Advance the shadow wheel by one request and queue the expiries it causes.
  function automatic void apply_request(input tws_in_t req);
    bit       hit [TIMERS];
    int       total;
    int       k;
    tws_out_t res;
    total = 0;
    k     = 0;
    case (req.kind)
      KIND_ADD: begin
        // Adding a live id simply replaces its schedule.
        if (req.timer_id < TIMERS) schedule_timer(req.timer_id, req.delay);
      end
      KIND_REARM: begin
        // Re-arm of an idle id is dropped.
        if (req.timer_id < TIMERS && wheel_armed[req.timer_id])
          schedule_timer(req.timer_id, req.delay);
      end
      KIND_DEL: begin
        if (req.timer_id < TIMERS) wheel_armed[req.timer_id] = 1'b0;
      end
      KIND_TICK: begin
        // Visit the current slot: count down rotations, retire the rest.
        for (int i = 0; i < TIMERS; i++) begin
          hit[i] = 1'b0;
          if (wheel_armed[i] && wheel_slot[i] == wheel_now) begin
            if (wheel_rounds[i] != 0) begin
              wheel_rounds[i] = wheel_rounds[i] - 1'b1;
            end else begin
              wheel_armed[i] = 1'b0;
              hit[i]         = 1'b1;
              total++;
            end
          end
        end
        // Emit in ascending id order, flag the final one. Up to all 32 timers can
        // expire on one tick, and every one of them is emitted.
        for (int i = 0; i < TIMERS; i++) begin
          if (hit[i]) begin
            k++;
            res.expired_id   = ID_W'(i);
            res.last_expired = (k == total);
            expiry_q.push_back(res);
          end
        end
        // A tick with nothing due still moves the wheel on.
        wheel_now = wheel_now + 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_expiry(input tws_out_t got);
    tws_out_t want;
    if (expiry_q.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: unexpected expiry id %0d last %0b",
                 $realtime, got.expired_id, got.last_expired);
      return;
    end
    want = expiry_q.pop_front();
    expiries_seen++;
    if (got.expired_id !== want.expired_id || got.last_expired !== want.last_expired) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: expiry mismatch: expected id %0d last %0b, got id %0d last %0b",
                 $realtime, want.expired_id, want.last_expired,
                 got.expired_id, got.last_expired);
    end
  endfunction

  // Sample both channels on the clock edge; values read here are pre-edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_expiry(out_res);
    if (rst_n && in_valid && in_ready) apply_request(in_req);
  end

  // Watchdog: count cycles in which no handshake and no register write occur.
  int stall_count = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_count <= 0;
    end else if (stall_count >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d expiries pending",
               $realtime, WATCHDOG_LIMIT, expiry_q.size());
      $display("[timing_wheel_scheduler] ERROR");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // Receiver: mostly ready, random stall bursts, and one long hold-off on demand.
  initial begin : expiry_sink
    int burst;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles > 0) begin
        burst            = sink_hold_cycles;
        sink_hold_cycles = 0;
        out_ready <= 1'b0;
        repeat (burst) @(posedge clk);
        out_ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. Every task here starts and ends right after a rising edge.
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until accepted. Valid stays high afterwards
  // so that back-to-back requests need no extra edge; the next call or
  // settle() drops it.
  task automatic send_request(input tws_kind_t kind, input bit [ID_W-1:0] id,
                              input bit [DELAY_W-1:0] delay);
    tws_in_t req;
    req.kind     = kind;
    req.timer_id = id;
    req.delay    = delay;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_req   <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Stop offering, wait for every owed expiry, then let any silent work finish.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expiry_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the interval register; only done with the block idle.
  task automatic write_interval(input bit [IVAL_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    wheel_interval = value;
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly delays a small number of ticks away so that timers do come due,
  // with zero delays and full-range delays mixed in.
  function automatic bit [DELAY_W-1:0] pick_delay();
    int unsigned divisor;
    divisor = (wheel_interval == 0) ? 1 : wheel_interval;
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return DELAY_W'($urandom_range(0, (1 << DELAY_W) - 1));
      default: return DELAY_W'(divisor * $urandom_range(0, 140)
                               + $urandom_range(0, divisor - 1));
    endcase
  endfunction

  task automatic random_traffic(input int count);
    bit [ID_W-1:0] id;
    repeat (count) begin
      id = ID_W'($urandom_range(0, TIMERS - 1));
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: send_request(KIND_ADD, id, pick_delay());
        7, 8, 9:             send_request(KIND_REARM, id, pick_delay());
        10, 11:              send_request(KIND_DEL, id, '0);
        default:             send_request(KIND_TICK, id, pick_delay());
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset interval, field extremes, every request kind and the ignore cases.
  task automatic test_directed_cases();
    send_request(KIND_TICK, '0, '0);               // empty wheel: nothing due
    send_request(KIND_ADD, 0, '0);                 // zero delay is one tick
    send_request(KIND_ADD, ID_W'(TIMERS - 1), '1); // largest delay, deepest rotation
    send_request(KIND_ADD, 5, 20'd63);             // one slot short of a turn
    send_request(KIND_ADD, 6, 20'd64);             // exactly one turn: same slot, round 1
    send_request(KIND_ADD, 7, 20'd3);
    send_request(KIND_REARM, 7, 20'd1);            // reschedule a live timer
    send_request(KIND_REARM, 9, 20'd2);            // idle id: drop
    send_request(KIND_DEL, 10, '1);                // idle id: drop
    send_request(KIND_ADD, 12, 20'd2);
    send_request(KIND_ADD, 12, '0);                // live id: replace schedule
    send_request(KIND_ADD, 13, 20'd2);
    send_request(KIND_DEL, 13, '0);                // cancel before it fires
    repeat (4) send_request(KIND_TICK, '1, '1);
    send_request(KIND_DEL, ID_W'(TIMERS - 1), '0);
  endtask

  // Interval of zero behaves as one; the largest interval rounds short delays
  // down to zero ticks.
  task automatic test_interval_extremes();
    write_interval('0);
    send_request(KIND_ADD, 3, 20'd2);
    send_request(KIND_ADD, 4, '0);
    repeat (3) send_request(KIND_TICK, '0, '0);
    write_interval('1);
    send_request(KIND_ADD, 8, 20'd5);              // below interval: current slot
    send_request(KIND_ADD, 9, 20'd1023);           // exactly one tick
    send_request(KIND_ADD, 10, '1);                // many turns out
    repeat (2) send_request(KIND_TICK, '0, '0);
    send_request(KIND_DEL, 10, '0);
  endtask

  // Arm every timer for the same tick, then hold the receiver off while the
  // sender keeps pushing, so the full burst of expiries backs up into the input.
  task automatic test_full_wheel_backpressure();
    settle();
    for (int i = 0; i < TIMERS; i++) send_request(KIND_ADD, ID_W'(i), '0);
    sink_hold_cycles = LONG_HOLD;
    repeat (2) send_request(KIND_TICK, '0, '0);
    for (int i = 0; i < 6; i++) send_request(KIND_ADD, ID_W'(2 * i), '0);
    repeat (2) send_request(KIND_TICK, '0, '0);
  endtask

  // Pause the sender until the wheel has delivered everything, then resume.
  task automatic test_drain_pause();
    for (int i = 0; i < 4; i++) send_request(KIND_ADD, ID_W'(20 + i), 20'(i));
    repeat (3) send_request(KIND_TICK, '0, '0);
    settle();
    repeat (2) send_request(KIND_TICK, '0, '0);
  endtask

  // Random mix across several interval settings.
  task automatic test_random_settings();
    write_interval(1);
    random_traffic(100);
    write_interval('1);
    random_traffic(90);
    write_interval(IVAL_W'($urandom_range(2, 16)));
    random_traffic(90);
    write_interval(IVAL_W'($urandom_range(17, 1022)));
    random_traffic(90);
  endtask

  // Closing stretch with both sides always ready.
  task automatic test_no_idle();
    write_interval(IVAL_W'($urandom_range(1, 4)));
    gaps_on = 1'b0;
    random_traffic(60);
  endtask

  initial begin : run_tests
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_interval_extremes();
    test_full_wheel_backpressure();
    test_drain_pause();
    test_random_settings();
    test_no_idle();

    settle();
    $display("Ran %0d requests over %0d interval settings; %0d expiries checked,",
             requests_sent, settings_used, expiries_seen);
    $display("including a full-wheel burst under a long receiver hold-off and a drain pause.");
    if (mismatches == 0 && expiry_q.size() == 0) begin
      $display("[timing_wheel_scheduler] OK");
    end else begin
      $display("%0d mismatches, %0d expiries never delivered", mismatches, expiry_q.size());
      $display("[timing_wheel_scheduler] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
